// File: sv/assert_macros.svh
// Assertion macros used by the controller of the cluster replacement table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HCRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define HCRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/hcrt_pkg.sv
// Types, constants and codes of the cluster replacement table.
package hcrt_pkg;

  // Store geometry
  localparam int NumClusters = 1024;
  localparam int Ways        = 3;
  localparam int ClusterBits = $clog2(NumClusters);
  localparam int WayBits     = 2;
  localparam int KeyBits     = 64;
  localparam int DepthBits   = 8;
  localparam int GbBits      = 8;
  localparam int PayloadBits = 48;
  localparam int KeepBits    = DepthBits + 2;

  // Generation and bound byte handling
  localparam logic [GbBits-1:0] LowBoundMask = 8'h07;
  localparam logic [GbBits-1:0] GenMask      = 8'hF8;
  localparam logic [9:0]        AgeBias      = 10'd263;

  // Operation codes
  localparam logic [1:0] OpProbe  = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

  // Register index
  localparam logic RegGeneration = 1'b0;

  typedef struct packed {
    logic [KeyBits-1:0]     key;
    logic [DepthBits-1:0]   depth;
    logic [GbBits-1:0]      gen_bound;
    logic [PayloadBits-1:0] payload;
  } entry_t;

  typedef entry_t [Ways-1:0] row_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the transaction and read its cluster
    logic sweep_we;  // zero the row under the sweep counter and advance
    logic commit;    // load the result and, for a probe or insert, write back the cluster
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
  } sts_t;

endpackage

// File: sv/hcrt_ctrl.sv
// Controller: sequences clearing sweeps, read and commit of each transaction.
`include "assert_macros.svh"

module hcrt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      opcode_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hcrt_pkg::cmd_t  cmd_o,
  input  hcrt_pkg::sts_t  sts_i
);

  localparam logic [1:0] StInit  = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;
  localparam logic [1:0] StSweep = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Decide the next state and the commands
  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.sweep_we = 1'b0;
    cmd_o.commit   = 1'b0;
    unique case (state_q)
      StInit: begin
        cmd_o.sweep_we = 1'b1;
        if (sts_i.sweep_last) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d = (opcode_i == hcrt_pkg::OpClear) ? StSweep : StExec;
        end
      end
      StSweep: begin
        cmd_o.sweep_we = 1'b1;
        if (sts_i.sweep_last) state_d = StExec;
      end
      StExec: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StInit;
    endcase
  end

  // Track the pending result
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `HCRT_ASSERT(a_accept_to_exec, (accept && opcode_i != hcrt_pkg::OpClear) |=> (state_q == StExec), "accepted transaction did not move to execute")
  `HCRT_ASSERT(a_stall_holds, (state_q == StExec && out_valid_q && !out_ready_i) |=> (state_q == StExec && out_valid_q), "execute did not hold behind a pending result")
  `HCRT_ASSERT(a_sweep_done, (state_q == StSweep && sts_i.sweep_last) |=> (state_q == StExec), "clear sweep did not end in a result")
  `HCRT_ASSERT(a_no_ready_in_sweep, (state_q == StInit || state_q == StSweep) |-> !in_ready_o, "transaction taken during a clearing sweep")

endmodule

// File: sv/hcrt_datapath.sv
// Datapath: cluster memory, way selection, replacement and result register.
module hcrt_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hcrt_pkg::cmd_t                       cmd_i,
  output hcrt_pkg::sts_t                       sts_o,
  input  logic [hcrt_pkg::GbBits-1:0]          gen_i,
  input  logic [1:0]                           opcode_i,
  input  logic [9:0]                           cluster_index_i,
  input  logic [hcrt_pkg::KeyBits-1:0]         key_i,
  input  logic [hcrt_pkg::DepthBits-1:0]       depth_i,
  input  logic [hcrt_pkg::GbBits-1:0]          gen_bound_i,
  input  logic [hcrt_pkg::PayloadBits-1:0]     payload_i,
  output logic                                 found_o,
  output logic [hcrt_pkg::WayBits-1:0]         way_o,
  output logic [hcrt_pkg::KeyBits-1:0]         entry_key_o,
  output logic [hcrt_pkg::DepthBits-1:0]       entry_depth_o,
  output logic [hcrt_pkg::GbBits-1:0]          entry_gen_bound_o,
  output logic [hcrt_pkg::PayloadBits-1:0]     entry_payload_o,
  output logic                                 written_o
);

  localparam int Ways = hcrt_pkg::Ways;
  localparam int CB   = hcrt_pkg::ClusterBits;

  hcrt_pkg::row_t mem [hcrt_pkg::NumClusters];

  hcrt_pkg::row_t                       rd_row_q, wr_row;
  hcrt_pkg::entry_t                     chosen;
  logic [1:0]                           op_q;
  logic [CB-1:0]                        cl_q;
  logic [hcrt_pkg::KeyBits-1:0]         key_q;
  logic [hcrt_pkg::DepthBits-1:0]       depth_q;
  logic [hcrt_pkg::GbBits-1:0]          gb_q;
  logic [hcrt_pkg::PayloadBits-1:0]     pl_q;
  logic [CB-1:0]                        sweep_cnt_q;
  logic                                 hit_any, found, overwrite;
  logic [hcrt_pkg::WayBits-1:0]         hit_way, best_way, sel;
  logic [hcrt_pkg::GbBits-1:0]          age [Ways];
  logic signed [hcrt_pkg::KeepBits-1:0] keep [Ways];

  assign sts_o.sweep_last = (sweep_cnt_q == CB'(hcrt_pkg::NumClusters - 1));

  // Latch the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      cl_q    <= cluster_index_i[CB-1:0];
      key_q   <= key_i;
      depth_q <= depth_i;
      gb_q    <= gen_bound_i;
      pl_q    <= payload_i;
    end
  end

  // Advance the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep_we) begin
      sweep_cnt_q <= sts_o.sweep_last ? '0 : sweep_cnt_q + 1'b1;
    end
  end

  // Cluster memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_we) begin
      mem[sweep_cnt_q] <= '0;
    end else if (cmd_i.commit && (op_q == hcrt_pkg::OpProbe || op_q == hcrt_pkg::OpInsert)) begin
      mem[cl_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) rd_row_q <= mem[cluster_index_i[CB-1:0]];
  end

  // Find the first way that matches the key or lies empty
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = 0; w < Ways; w++) begin
      if (!hit_any && (rd_row_q[w].key == key_q || rd_row_q[w].depth == '0)) begin
        hit_any = 1'b1;
        hit_way = hcrt_pkg::WayBits'(w);
      end
    end
  end

  // Weigh each way by depth less its wrapped age
  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      age[w]  = 8'(hcrt_pkg::AgeBias + 10'(gen_i) - 10'(rd_row_q[w].gen_bound))
                & hcrt_pkg::GenMask;
      keep[w] = $signed({2'b00, rd_row_q[w].depth}) - $signed({2'b00, age[w]});
    end
  end

  // Take the lowest weight, the first way on a tie
  always_comb begin
    best_way = '0;
    for (int w = 1; w < Ways; w++) begin
      if (keep[best_way] > keep[w]) best_way = hcrt_pkg::WayBits'(w);
    end
  end

  // Refresh or replace the chosen entry
  always_comb begin
    sel    = hit_any ? hit_way : best_way;
    chosen = rd_row_q[sel];
    if (hit_any) begin
      chosen.gen_bound = gen_i | (chosen.gen_bound & hcrt_pkg::LowBoundMask);
    end
    found     = hit_any && (chosen.depth != '0);
    overwrite = (op_q == hcrt_pkg::OpInsert) && (depth_q > chosen.depth);
    if (overwrite) begin
      chosen.key       = key_q;
      chosen.depth     = depth_q;
      chosen.gen_bound = gb_q;
      chosen.payload   = pl_q;
    end
    wr_row      = rd_row_q;
    wr_row[sel] = chosen;
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      unique case (op_q)
        hcrt_pkg::OpProbe, hcrt_pkg::OpInsert: begin
          found_o           <= found;
          way_o             <= sel;
          entry_key_o       <= chosen.key;
          entry_depth_o     <= chosen.depth;
          entry_gen_bound_o <= chosen.gen_bound;
          entry_payload_o   <= chosen.payload;
          written_o         <= overwrite;
        end
        default: begin
          found_o           <= 1'b0;
          way_o             <= '0;
          entry_key_o       <= '0;
          entry_depth_o     <= '0;
          entry_gen_bound_o <= '0;
          entry_payload_o   <= '0;
          written_o         <= (op_q == hcrt_pkg::OpClear);
        end
      endcase
    end
  end

endmodule

// File: sv/hash_cluster_replace_table_top.sv
// Top level of the cluster replacement table: register port, controller and datapath.
//
// The table holds 1024 clusters of three entries in one row-wide memory. For a probe or an
// insert the cluster row is read at the edge that accepts the transaction; then, in the
// execute state, the way is chosen and the row written back while the result is loaded.
// One transaction is in flight at a time, and a result not yet taken holds the write-back.
// A clear zeroes the memory one row a cycle, then loads its result in the execute state.
// After reset the same clearing pass runs, during which no transaction is accepted;
// register writes are taken as ever. The generation register is decoded from paddr[2]
// alone, so it answers at byte addresses 0 to 3, and keeps only its upper five bits.
module hash_cluster_replace_table_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           opcode_i,
  input  logic [9:0]                           cluster_index_i,
  input  logic [hcrt_pkg::KeyBits-1:0]         key_i,
  input  logic [hcrt_pkg::DepthBits-1:0]       depth_i,
  input  logic [hcrt_pkg::GbBits-1:0]          gen_bound_i,
  input  logic [hcrt_pkg::PayloadBits-1:0]     payload_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 found_o,
  output logic [hcrt_pkg::WayBits-1:0]         way_o,
  output logic [hcrt_pkg::KeyBits-1:0]         entry_key_o,
  output logic [hcrt_pkg::DepthBits-1:0]       entry_depth_o,
  output logic [hcrt_pkg::GbBits-1:0]          entry_gen_bound_o,
  output logic [hcrt_pkg::PayloadBits-1:0]     entry_payload_o,
  output logic                                 written_o
);

  logic [hcrt_pkg::GbBits-1:0] gen_q;
  logic                        gen_sel;
  hcrt_pkg::cmd_t              cmd;
  hcrt_pkg::sts_t              sts;

  // Decode the register port
  assign pready  = 1'b1;
  assign gen_sel = (paddr[2] == hcrt_pkg::RegGeneration);
  assign prdata  = gen_sel ? {24'd0, gen_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (psel && penable && pwrite && pready && gen_sel) begin
      gen_q <= pwdata[hcrt_pkg::GbBits-1:0] & hcrt_pkg::GenMask;
    end
  end

  hcrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  hcrt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .gen_i             (gen_q),
    .opcode_i          (opcode_i),
    .cluster_index_i   (cluster_index_i),
    .key_i             (key_i),
    .depth_i           (depth_i),
    .gen_bound_i       (gen_bound_i),
    .payload_i         (payload_i),
    .found_o           (found_o),
    .way_o             (way_o),
    .entry_key_o       (entry_key_o),
    .entry_depth_o     (entry_depth_o),
    .entry_gen_bound_o (entry_gen_bound_o),
    .entry_payload_o   (entry_payload_o),
    .written_o         (written_o)
  );

endmodule
